>>> rtl/core/assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

>>> rtl/core/hni_pkg.sv
`timescale 1ns / 1ps

package hni_pkg;

	localparam int SITE_W  = 17;
	localparam int CELL_W  = SITE_W - 1;
	localparam int CFG_W   = 9;
	localparam int CFG_MAX = 2 ** CFG_W - 1;
	localparam int NS1_W   = CFG_W + 1;
	localparam int PROD_W  = 2 * CFG_W;
	localparam int NS2_W   = PROD_W + 1;
	localparam int MODE_W  = 2;
	localparam int DIM_W   = 2;
	localparam int ADDR_W  = 2;

	localparam int DIV_BITS = 2;

	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 56;

	localparam int MAX_CELLS_X_DEF = 256;
	localparam int MAX_CELLS_Y_DEF = 256;

	localparam logic [CFG_W-1:0] CELLS_X_RST = CFG_W'(4);
	localparam logic [CFG_W-1:0] CELLS_Y_RST = CFG_W'(4);

	typedef enum logic [ADDR_W-1:0] {
		CFG_CELLS_X   = 2'd0,
		CFG_CELLS_Y   = 2'd1,
		CFG_BOUNDARY  = 2'd2,
		CFG_DIMENSION = 2'd3
	} cfg_reg_t;

	typedef enum logic [MODE_W-1:0] {
		BND_PERIODIC   = 2'd0,
		BND_OPEN       = 2'd1,
		BND_PERIODIC_X = 2'd2,
		BND_PERIODIC_Y = 2'd3
	} bnd_mode_t;

	localparam logic [DIM_W-1:0] DIM_CHAIN = 2'd1;
	localparam logic [DIM_W-1:0] DIM_PLANE = 2'd2;

	// Lattice geometry derived from the configuration registers
	typedef struct packed {
		logic [CFG_W-1:0] cx;
		logic [CFG_W-1:0] cy;
		logic [NS1_W-1:0] ns1;
		logic [NS2_W-1:0] ns2;
		logic             px;
		logic             py;
		logic             chain;
		logic             chain_open;
	} geom_t;

	typedef struct packed {
		logic [SITE_W-1:0] site;
		logic              oor;
	} lookup_t;

	typedef struct packed {
		lookup_t          tag;
		logic [CELL_W-1:0] quo;
		logic [CFG_W-1:0]  rem;
	} div_res_t;

	// Field order matches m_axis_tdata, lowest field last
	typedef struct packed {
		logic              pad;
		logic              oor;
		logic              xv;
		logic [SITE_W-1:0] xn;
		logic              yv;
		logic [SITE_W-1:0] yn;
		logic              zv;
		logic [SITE_W-1:0] zn;
	} res_t;

endpackage

>>> rtl/core/hni_cfg.sv
`timescale 1ns / 1ps

module hni_cfg import hni_pkg::*; #(
	parameter int MAX_CELLS_X = MAX_CELLS_X_DEF,
	parameter int MAX_CELLS_Y = MAX_CELLS_Y_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              we,
	input  logic [ADDR_W-1:0] addr,
	input  logic [CFG_W-1:0]  wdata,
	output geom_t             geom
);

	localparam logic [CFG_W-1:0] CAP_X =
		(MAX_CELLS_X > CFG_MAX) ? CFG_W'(CFG_MAX) : CFG_W'(MAX_CELLS_X);
	localparam logic [CFG_W-1:0] CAP_Y =
		(MAX_CELLS_Y > CFG_MAX) ? CFG_W'(CFG_MAX) : CFG_W'(MAX_CELLS_Y);

	logic [CFG_W-1:0]  cells_x_q;
	logic [CFG_W-1:0]  cells_y_q;
	bnd_mode_t         mode_q;
	logic [DIM_W-1:0]  dim_q;
	geom_t             geom_q;
	geom_t             geom_d;
	logic [PROD_W-1:0] area;

	function automatic logic [CFG_W-1:0] eff_cells(input logic [CFG_W-1:0] v,
			input logic [CFG_W-1:0] cap);
		if (v == '0) begin
			return CFG_W'(1);
		end else if (v > cap) begin
			return cap;
		end else begin
			return v;
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_x_q <= CELLS_X_RST;
			cells_y_q <= CELLS_Y_RST;
			mode_q    <= BND_PERIODIC;
			dim_q     <= DIM_PLANE;
		end else if (we) begin
			unique case (cfg_reg_t'(addr))
				CFG_CELLS_X:   cells_x_q <= wdata;
				CFG_CELLS_Y:   cells_y_q <= wdata;
				CFG_BOUNDARY:  mode_q    <= bnd_mode_t'(wdata[MODE_W-1:0]);
				CFG_DIMENSION: dim_q     <= wdata[DIM_W-1:0];
			endcase
		end
	end

	always_comb begin
		geom_d.cx = eff_cells(cells_x_q, CAP_X);
		geom_d.cy = eff_cells(cells_y_q, CAP_Y);
		area = {{CFG_W{1'b0}}, geom_d.cx} * {{CFG_W{1'b0}}, geom_d.cy};
		geom_d.ns1 = {geom_d.cx, 1'b0};
		geom_d.ns2 = {area, 1'b0};
		geom_d.px = (mode_q == BND_PERIODIC) || (mode_q == BND_PERIODIC_X);
		geom_d.py = (mode_q == BND_PERIODIC) || (mode_q == BND_PERIODIC_Y);
		geom_d.chain = (dim_q == DIM_CHAIN);
		geom_d.chain_open = (mode_q == BND_OPEN);
	end

	// Registered copy of the geometry; items first read it once accepted into the input register
	always_ff @(posedge clk) begin
		geom_q <= geom_d;
	end

	assign geom = geom_q;

endmodule

>>> rtl/core/hni_div.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hni_div import hni_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CFG_W-1:0] cx,
	input  logic             in_valid,
	output logic             in_ready,
	input  lookup_t          in_tag,
	output logic             out_valid,
	input  logic             out_ready,
	output div_res_t         out_res
);

	localparam int STAGES = CELL_W / DIV_BITS;

	typedef struct packed {
		lookup_t           tag;
		logic [CELL_W-1:0] work;
		logic [CFG_W-1:0]  rem;
	} dstage_t;

	dstage_t             div_s  [STAGES];
	dstage_t             prev_d [STAGES];
	logic [STAGES-1:0]   v_s;
	logic [STAGES-1:0]   prev_v;
	logic [STAGES-1:0]   ld;
	logic [PROD_W+CELL_W-1:0] chk_lhs;
	logic [PROD_W+CELL_W-1:0] chk_rhs;

	// Restoring division, DIV_BITS quotient bits per stage. The work word
	// shifts dividend bits out at the top and quotient bits in at the bottom.
	function automatic dstage_t div_steps(input dstage_t d, input logic [CFG_W-1:0] dv);
		dstage_t        r;
		logic [CFG_W:0] part;
		logic           qb;
		r = d;
		for (int k = 0; k < DIV_BITS; k++) begin
			part = {r.rem, r.work[CELL_W-1]};
			qb = (part >= {1'b0, dv});
			if (qb) begin
				part = part - {1'b0, dv};
			end
			r.rem  = part[CFG_W-1:0];
			r.work = {r.work[CELL_W-2:0], qb};
		end
		return r;
	endfunction

	always_comb begin
		prev_v[0]       = in_valid;
		prev_d[0].tag   = in_tag;
		prev_d[0].work  = in_tag.site[SITE_W-1:1];
		prev_d[0].rem   = '0;
		for (int k = 1; k < STAGES; k++) begin
			prev_v[k] = v_s[k-1];
			prev_d[k] = div_s[k-1];
		end
	end

	// Advance a stage when it is empty or its item moves on
	always_comb begin
		ld[STAGES-1] = !v_s[STAGES-1] || out_ready;
		for (int k = STAGES - 2; k >= 0; k--) begin
			ld[k] = !v_s[k] || ld[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			for (int k = 0; k < STAGES; k++) begin
				if (ld[k]) begin
					v_s[k] <= prev_v[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < STAGES; k++) begin
			if (ld[k]) begin
				div_s[k] <= div_steps(prev_d[k], cx);
			end
		end
	end

	assign in_ready    = ld[0];
	assign out_valid   = v_s[STAGES-1];
	assign out_res.tag = div_s[STAGES-1].tag;
	assign out_res.quo = div_s[STAGES-1].work;
	assign out_res.rem = div_s[STAGES-1].rem;

	assign chk_lhs = {{PROD_W{1'b0}}, out_res.quo} * {{(PROD_W+CELL_W-CFG_W){1'b0}}, cx}
		+ {{(PROD_W+CELL_W-CFG_W){1'b0}}, out_res.rem};
	assign chk_rhs = {{PROD_W{1'b0}}, out_res.tag.site[SITE_W-1:1]};

	`ASSERT_PROP(a_rem_below_divisor, clk, arst_n, out_valid |-> (out_res.rem < cx), "remainder not below cell count")
	`ASSERT_PROP(a_quotient_exact, clk, arst_n, out_valid |-> (chk_lhs == chk_rhs), "quotient times divisor plus remainder differs from cell")

endmodule

>>> rtl/core/hni_nbr.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hni_nbr import hni_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  geom_t    geom,
	input  logic     in_valid,
	output logic     in_ready,
	input  div_res_t in_res,
	output logic     out_valid,
	input  logic     out_ready,
	output res_t     out_res
);

	typedef struct packed {
		logic              oor;
		logic              chain;
		logic              sub;
		logic [SITE_W-1:0] site;
		logic [SITE_W-1:0] zc;
		logic              zcv;
		logic [SITE_W-1:0] yc;
		logic              ycv;
		logic [CFG_W-1:0]  niy;
		logic              yv;
		logic [CFG_W-1:0]  nix;
		logic              xv;
		logic [CFG_W-1:0]  nj;
	} bond_t;

	bond_t             bond_d;
	bond_t             bond_s1;
	bond_t             bond_s2;
	logic [PROD_W-1:0] row_s2;
	res_t              res_d;
	res_t              res_s3;
	logic              v_s1, v_s2, v_s3;
	logic              ld1, ld2, ld3;

	logic [CFG_W-1:0]  i_c, j_c, ip, im, jp, jm, nyi, nxi;
	logic              ipv, imv, jpv, jmv, njv, nyv, nxv, sub, odd;
	logic [PROD_W-1:0] by, bx;

	// Stage 1: wrapped cell steps and chain neighbors
	always_comb begin
		i_c = in_res.rem;
		j_c = in_res.quo[CFG_W-1:0];
		sub = in_res.tag.site[0];
		odd = j_c[0];

		ip = '0; ipv = 1'b0;
		if (({1'b0, i_c} + (CFG_W+1)'(1)) < {1'b0, geom.cx}) begin
			ip = i_c + 1'b1; ipv = 1'b1;
		end else if (geom.px) begin
			ipv = 1'b1;
		end

		im = '0; imv = 1'b0;
		if (i_c != '0) begin
			im = i_c - 1'b1; imv = 1'b1;
		end else if (geom.px) begin
			im = geom.cx - 1'b1; imv = 1'b1;
		end

		jp = '0; jpv = 1'b0;
		if (({1'b0, j_c} + (CFG_W+1)'(1)) < {1'b0, geom.cy}) begin
			jp = j_c + 1'b1; jpv = 1'b1;
		end else if (geom.py) begin
			jpv = 1'b1;
		end

		jm = '0; jmv = 1'b0;
		if (j_c != '0) begin
			jm = j_c - 1'b1; jmv = 1'b1;
		end else if (geom.py) begin
			jm = geom.cy - 1'b1; jmv = 1'b1;
		end

		// Upper site bonds go a row up, lower site bonds a row down
		bond_d.nj = sub ? jp : jm;
		njv       = sub ? jpv : jmv;

		priority if (!sub && odd) begin
			nyi = ip; nyv = ipv;
		end else if (sub && !odd) begin
			nyi = im; nyv = imv;
		end else begin
			nyi = i_c; nyv = 1'b1;
		end

		priority if (sub && odd) begin
			nxi = ip; nxv = ipv;
		end else if (!sub && !odd) begin
			nxi = im; nxv = imv;
		end else begin
			nxi = i_c; nxv = 1'b1;
		end

		bond_d.oor   = in_res.tag.oor;
		bond_d.chain = geom.chain;
		bond_d.sub   = sub;
		bond_d.site  = in_res.tag.site;
		bond_d.niy   = nyi;
		bond_d.yv    = nyv && njv;
		bond_d.nix   = nxi;
		bond_d.xv    = nxv && njv;

		bond_d.zc = '0; bond_d.zcv = 1'b0;
		if (({1'b0, in_res.tag.site} + (SITE_W+1)'(1))
				< {{(SITE_W+1-NS1_W){1'b0}}, geom.ns1}) begin
			bond_d.zc = in_res.tag.site + 1'b1; bond_d.zcv = 1'b1;
		end else if (!geom.chain_open) begin
			bond_d.zcv = 1'b1;
		end

		bond_d.yc = '0; bond_d.ycv = 1'b0;
		if (in_res.tag.site != '0) begin
			bond_d.yc = in_res.tag.site - 1'b1; bond_d.ycv = 1'b1;
		end else if (!geom.chain_open) begin
			bond_d.yc = {{(SITE_W-NS1_W){1'b0}}, geom.ns1} - 1'b1; bond_d.ycv = 1'b1;
		end
	end

	// Stage 3: assemble site numbers from row base and column
	always_comb begin
		by = row_s2 + {{CFG_W{1'b0}}, bond_s2.niy};
		bx = row_s2 + {{CFG_W{1'b0}}, bond_s2.nix};
		res_d = '0;
		priority if (bond_s2.oor) begin
			res_d.oor = 1'b1;
		end else if (bond_s2.chain) begin
			res_d.zv = bond_s2.zcv;
			res_d.zn = bond_s2.zcv ? bond_s2.zc : '0;
			res_d.yv = bond_s2.ycv;
			res_d.yn = bond_s2.ycv ? bond_s2.yc : '0;
		end else begin
			res_d.zv = 1'b1;
			res_d.zn = bond_s2.site ^ SITE_W'(1);
			res_d.yv = bond_s2.yv;
			res_d.yn = bond_s2.yv ? SITE_W'({by, ~bond_s2.sub}) : '0;
			res_d.xv = bond_s2.xv;
			res_d.xn = bond_s2.xv ? SITE_W'({bx, ~bond_s2.sub}) : '0;
		end
	end

	assign ld3 = !v_s3 || out_ready;
	assign ld2 = !v_s2 || ld3;
	assign ld1 = !v_s1 || ld2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (ld1) begin
				v_s1 <= in_valid;
			end
			if (ld2) begin
				v_s2 <= v_s1;
			end
			if (ld3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			bond_s1 <= bond_d;
		end
		if (ld2) begin
			bond_s2 <= bond_s1;
			row_s2  <= {{CFG_W{1'b0}}, geom.cx} * {{CFG_W{1'b0}}, bond_s1.nj};
		end
		if (ld3) begin
			res_s3 <= res_d;
		end
	end

	assign in_ready  = ld1;
	assign out_valid = v_s3;
	assign out_res   = res_s3;

	`ASSERT_PROP(a_oor_clears_all, clk, arst_n, (out_valid && out_res.oor) |-> ((out_res.zv || out_res.yv || out_res.xv) == 1'b0 && (out_res.zn | out_res.yn | out_res.xn) == '0), "out of range site has a neighbor")
	`ASSERT_NEVER(a_chain_no_x, clk, arst_n, out_valid && geom.chain && out_res.xv, "x bond reported in chain mode")
	`ASSERT_PROP(a_plane_has_partner, clk, arst_n, (out_valid && !out_res.oor && !geom.chain) |-> out_res.zv, "in range plane site lacks cell partner")

endmodule

>>> rtl/core/honeycomb_neighbor_index.sv
`timescale 1ns / 1ps
// Honeycomb lattice neighbor lookup.
// Input stream s_axis carries one site index per item; output stream m_axis
// returns its z, y and x bond neighbors with valid flags and an out-of-range
// flag, one result item per input item, in order.
// The configuration port (cfg_we, cfg_addr, cfg_wdata) sets cells_x (0),
// cells_y (1), boundary_mode (2) and dimension (3); write it only while no
// item is in flight.
// Throughput: one item per cycle while m_axis_tready stays high. Row and column
// come from a pipelined restoring divider (cell index site >> 1 divided by
// cells_x, two quotient bits per stage, 8 stages), followed by a step/wrap
// stage, a row multiply stage and the output register.
// Reset empties the pipeline and loads cells_x = cells_y = 4, periodic
// boundaries and the plane lattice.
// When m_axis_tready is low the result holds; empty stages keep filling, so
// s_axis_tready drops only once every stage holds an item.

module honeycomb_neighbor_index import hni_pkg::*; #(
	parameter int MAX_CELLS_X = MAX_CELLS_X_DEF,
	parameter int MAX_CELLS_Y = MAX_CELLS_Y_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [ADDR_W-1:0]      cfg_addr,
	input  logic [CFG_W-1:0]       cfg_wdata,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// site_index [16:0], zero fill above
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// z_neighbor [16:0], z_valid [17], y_neighbor [34:18], y_valid [35],
	// x_neighbor [52:36], x_valid [53], site_out_of_range [54], zero [55]
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	geom_t             geom;
	logic [SITE_W-1:0] site_s1;
	logic              valid_s1;
	logic              ld_s1;
	logic              oor;
	lookup_t           div_tag;
	logic              div_in_ready;
	logic              div_out_valid;
	div_res_t          div_res;
	logic              nbr_in_ready;
	res_t              res;

	hni_cfg #(
		.MAX_CELLS_X(MAX_CELLS_X),
		.MAX_CELLS_Y(MAX_CELLS_Y)
	) u_cfg (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (cfg_we),
		.addr  (cfg_addr),
		.wdata (cfg_wdata),
		.geom  (geom)
	);

	assign ld_s1         = !valid_s1 || div_in_ready;
	assign s_axis_tready = ld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ld_s1) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			site_s1 <= s_axis_tdata[SITE_W-1:0];
		end
	end

	always_comb begin
		if (geom.chain) begin
			oor = site_s1 >= {{(SITE_W-NS1_W){1'b0}}, geom.ns1};
		end else begin
			oor = {{(NS2_W-SITE_W){1'b0}}, site_s1} >= geom.ns2;
		end
		div_tag.site = site_s1;
		div_tag.oor  = oor;
	end

	hni_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.cx       (geom.cx),
		.in_valid (valid_s1),
		.in_ready (div_in_ready),
		.in_tag   (div_tag),
		.out_valid(div_out_valid),
		.out_ready(nbr_in_ready),
		.out_res  (div_res)
	);

	hni_nbr u_nbr (
		.clk      (clk),
		.arst_n   (arst_n),
		.geom     (geom),
		.in_valid (div_out_valid),
		.in_ready (nbr_in_ready),
		.in_res   (div_res),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_res  (res)
	);

	assign m_axis_tdata = res;

endmodule
